// ----- sv/rld_pkg.sv -----
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants of the pixel run-length decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

   localparam int MAX_PIXEL_BYTES_DEFAULT = 4;

   localparam int BPP_W    = 3;
   localparam int IMAGE_W  = 31;
   localparam int BYTE_W   = 8;
   localparam int PIXEL_W  = 32;
   localparam int RUN_W    = 8;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 4;   // holds a pixel size up to eight
   localparam int NEED_W   = RUN_W + SIZE_W;
   localparam int PACK_LANES = PIXEL_W / BYTE_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
   localparam logic [IMAGE_W-1:0] IMAGE_RESET = 31'd1;

   typedef enum logic [0:0] {
      REG_BYTES_PER_PIXEL = 1'b0,
      REG_IMAGE_BYTES     = 1'b1
   } rld_reg_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_RUN   = 3'd0,
      STATUS_DONE  = 3'd1,
      STATUS_ZERO  = 3'd2,
      STATUS_OVER  = 3'd3,
      STATUS_TRUNC = 3'd4
   } rld_status_type;

   typedef struct packed {
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [IMAGE_W-1:0] image_bytes;
   } rld_cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [RUN_W-1:0]   run_length;
      rld_status_type     status;
   } rld_result_type;

endpackage

// ----- sv/pixel_run_length_decoder.sv -----
// ----------------------------------------------------------------------------
// pixel_run_length_decoder
// Run-length pixel stream decoder: one compressed byte in, one run result out.
// ----------------------------------------------------------------------------
// One compressed byte is taken per cycle unless req_stall holds it off, and
// the result it causes (if any) shows in the result register in the next
// cycle. The input stalls only while that register holds an unread item and
// the result side stalls; the decode state update itself is a single short
// step per byte. Results appear only when a pixel completes or an error is
// detected, so the result rate is at most one per byte. No clearing pass is
// needed after reset. Configuration (bytes_per_pixel at 0x0, image_bytes at
// 0x4) is to be written by the user only while the stream is idle; the
// block does not enforce this. Pixel size is clamped to 1..MAX_PIXEL_BYTES.
// ----------------------------------------------------------------------------
module pixel_run_length_decoder #(
   parameter int MAX_PIXEL_BYTES = rld_pkg::MAX_PIXEL_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   // input channel: one stream byte per item
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rld_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                              req_last_byte,

   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rld_pkg::PIXEL_W-1:0]       rsp_pixel_value,
   output logic [rld_pkg::RUN_W-1:0]         rsp_run_length,
   output logic [rld_pkg::STATUS_W-1:0]      rsp_status,

   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rld_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rld_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rld_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   rld_pkg::rld_cfg_type    cfg;
   rld_pkg::rld_result_type core_result;
   rld_pkg::rld_result_type held_result;
   logic                    accept;
   logic                    emit;
   logic                    out_busy;

   // registers
   rld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // hold off input only when the result register cannot take a new item
   assign req_stall = out_busy;
   assign accept    = req_valid & ~out_busy;

   // decode state and per-byte update
   rld_core #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cfg       (cfg),
      .emit      (emit),
      .result    (core_result)
   );

   // result register
   rld_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (emit),
      .load_result (core_result),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_result  (held_result),
      .busy        (out_busy)
   );

   assign rsp_pixel_value = held_result.pixel_value;
   assign rsp_run_length  = held_result.run_length;
   assign rsp_status      = held_result.status;

endmodule

// ----- sv/rld_csr.sv -----
// ----------------------------------------------------------------------------
// rld_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module rld_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rld_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rld_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rld_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output rld_pkg::rld_cfg_type               cfg
);

   logic [rld_pkg::BPP_W-1:0]   bpp_ff;
   logic [rld_pkg::IMAGE_W-1:0] image_ff;
   logic                        wr_en;
   rld_pkg::rld_reg_type        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   // word index; low address bits ignored
   assign reg_sel    = rld_pkg::rld_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= rld_pkg::BPP_RESET;
         image_ff <= rld_pkg::IMAGE_RESET;
      end else if (wr_en) begin
         if (reg_sel == rld_pkg::REG_IMAGE_BYTES) begin
            image_ff <= csr_pwdata[rld_pkg::IMAGE_W-1:0];
         end else begin
            bpp_ff <= csr_pwdata[rld_pkg::BPP_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == rld_pkg::REG_IMAGE_BYTES) begin
         csr_prdata = {{(rld_pkg::CSR_DATA_W-rld_pkg::IMAGE_W){1'b0}}, image_ff};
      end else begin
         csr_prdata = {{(rld_pkg::CSR_DATA_W-rld_pkg::BPP_W){1'b0}}, bpp_ff};
      end
   end

   assign cfg.bytes_per_pixel = bpp_ff;
   assign cfg.image_bytes     = image_ff;

endmodule

// ----- sv/rld_core.sv -----
// ----------------------------------------------------------------------------
// rld_core
// Decode state and the per-byte update; gives at most one result per item.
// ----------------------------------------------------------------------------
module rld_core #(
   parameter int MAX_PIXEL_BYTES = rld_pkg::MAX_PIXEL_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rld_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          last_byte,
   input  rld_pkg::rld_cfg_type          cfg,
   output logic                          emit,
   output rld_pkg::rld_result_type       result
);

   localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam logic [rld_pkg::SIZE_W-1:0] PIXEL_SIZE_LIMIT =
      rld_pkg::SIZE_W'(MAX_PIXEL_BYTES);

   logic                          expecting_ff, expecting_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [rld_pkg::RUN_W-1:0]     pending_ff, pending_in;
   logic [rld_pkg::PIXEL_W-1:0]   acc_ff, acc_in;
   logic [rld_pkg::IMAGE_W-1:0]   decoded_ff, decoded_in;
   logic                          finished_ff, finished_in;
   logic                          error_ff, error_in;

   logic [rld_pkg::SIZE_W-1:0]    size;
   logic [rld_pkg::SIZE_W-1:0]    idx_plus;
   logic [rld_pkg::PIXEL_W-1:0]   acc_packed;
   logic [rld_pkg::NEED_W-1:0]    need;
   logic [rld_pkg::IMAGE_W-1:0]   room;
   logic [rld_pkg::IMAGE_W-1:0]   need_ext;
   logic [rld_pkg::IMAGE_W-1:0]   sum;

   // clamp pixel size to 1..MAX_PIXEL_BYTES
   always_comb begin
      if (cfg.bytes_per_pixel == '0) begin
         size = rld_pkg::SIZE_W'(1);
      end else if (rld_pkg::SIZE_W'(cfg.bytes_per_pixel) > PIXEL_SIZE_LIMIT) begin
         size = PIXEL_SIZE_LIMIT;
      end else begin
         size = rld_pkg::SIZE_W'(cfg.bytes_per_pixel);
      end
   end

   assign idx_plus = rld_pkg::SIZE_W'(idx_ff) + rld_pkg::SIZE_W'(1);

   // byte lanes; bytes past the fourth match no lane
   always_comb begin
      acc_packed = acc_ff;
      for (int k = 0; k < rld_pkg::PACK_LANES; k++) begin
         if (int'(idx_ff) == k) begin
            acc_packed[k*rld_pkg::BYTE_W +: rld_pkg::BYTE_W] =
               acc_ff[k*rld_pkg::BYTE_W +: rld_pkg::BYTE_W] | data_byte;
         end
      end
   end

   assign need     = rld_pkg::NEED_W'(pending_ff) * rld_pkg::NEED_W'(size);
   assign need_ext = rld_pkg::IMAGE_W'(need);
   assign room     = (decoded_ff >= cfg.image_bytes) ? '0 : (cfg.image_bytes - decoded_ff);
   assign sum      = decoded_ff + need_ext;

   always_comb begin
      expecting_in = expecting_ff;
      idx_in       = idx_ff;
      pending_in   = pending_ff;
      acc_in       = acc_ff;
      decoded_in   = decoded_ff;
      finished_in  = finished_ff;
      error_in     = error_ff;
      emit         = 1'b0;
      result.pixel_value = '0;
      result.run_length  = '0;
      result.status      = rld_pkg::STATUS_RUN;

      if (accept) begin
         if (finished_ff || error_ff) begin
            // dropped until the stream's last byte
         end else if (expecting_ff) begin
            if (data_byte == '0) begin
               emit          = 1'b1;
               result.status = rld_pkg::STATUS_ZERO;
               error_in      = 1'b1;
            end else if (last_byte) begin
               emit          = 1'b1;
               result.status = rld_pkg::STATUS_TRUNC;
               error_in      = 1'b1;
            end else begin
               pending_in   = data_byte;
               idx_in       = '0;
               acc_in       = '0;
               expecting_in = 1'b0;
            end
         end else begin
            acc_in = acc_packed;
            idx_in = IDX_W'(idx_plus);
            if (idx_plus >= size) begin
               emit         = 1'b1;
               expecting_in = 1'b1;
               idx_in       = '0;
               if (need_ext > room) begin
                  result.status = rld_pkg::STATUS_OVER;
                  error_in      = 1'b1;
               end else begin
                  decoded_in = sum;
                  if (sum == cfg.image_bytes) begin
                     result.pixel_value = acc_packed;
                     result.run_length  = pending_ff;
                     result.status      = rld_pkg::STATUS_DONE;
                     finished_in        = 1'b1;
                  end else if (last_byte) begin
                     result.status = rld_pkg::STATUS_TRUNC;
                     error_in      = 1'b1;
                  end else begin
                     result.pixel_value = acc_packed;
                     result.run_length  = pending_ff;
                  end
               end
            end else if (last_byte) begin
               emit          = 1'b1;
               result.status = rld_pkg::STATUS_TRUNC;
               error_in      = 1'b1;
            end
         end

         if (last_byte) begin
            expecting_in = 1'b1;
            idx_in       = '0;
            pending_in   = '0;
            acc_in       = '0;
            decoded_in   = '0;
            finished_in  = 1'b0;
            error_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expecting_ff <= 1'b1;
         idx_ff       <= '0;
         pending_ff   <= '0;
         acc_ff       <= '0;
         decoded_ff   <= '0;
         finished_ff  <= 1'b0;
         error_ff     <= 1'b0;
      end else begin
         expecting_ff <= expecting_in;
         idx_ff       <= idx_in;
         pending_ff   <= pending_in;
         acc_ff       <= acc_in;
         decoded_ff   <= decoded_in;
         finished_ff  <= finished_in;
         error_ff     <= error_in;
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(finished_ff && error_ff))
      else $error("finished and error both set");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> expecting_ff && !finished_ff && !error_ff && decoded_ff == '0)
      else $error("last byte did not re-arm");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      emit && (result.status == rld_pkg::STATUS_RUN || result.status == rld_pkg::STATUS_DONE)
      |-> result.run_length != '0)
      else $error("run result with zero length");

   a_error_blank: assert property (@(posedge clock) disable iff (reset)
      emit && (result.status == rld_pkg::STATUS_ZERO || result.status == rld_pkg::STATUS_OVER
               || result.status == rld_pkg::STATUS_TRUNC)
      |-> result.run_length == '0 && result.pixel_value == '0)
      else $error("error result carries pixel data");

endmodule

// ----- sv/rld_out_reg.sv -----
// ----------------------------------------------------------------------------
// rld_out_reg
// Result register; frees the input side as soon as the held item is taken.
// ----------------------------------------------------------------------------
module rld_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  rld_pkg::rld_result_type   load_result,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output rld_pkg::rld_result_type   rsp_result,
   output logic                      busy
);

   logic                    valid_ff, valid_in;
   rld_pkg::rld_result_type result_ff;

   assign busy = valid_ff & rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel run-length decoder.
// ----------------------------------------------------------------------------
// Stream bytes go in over the valid/stall input channel. Each accepted item
// also steps a local decode model, which queues the result it should cause.
// A monitor pops that queue for every accepted result item and compares all
// fields. Directed tests cover the reset settings, the widest pixels, single
// byte pixels, size clamping and a shrunk image. Random streams follow:
// mostly well-formed images, plus cut, zero-count, overrun, junk-tailed,
// noise and reconfigured-mid-stream streams. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import rld_pkg::*;

   localparam int          PIXEL_BYTES_MAX = MAX_PIXEL_BYTES_DEFAULT;
   localparam int          RANDOM_ITEMS    = 1000;
   localparam int          SETTLE_CYCLES   = 4;      // block latency plus margin
   localparam int          DRAIN_LIMIT     = 2000;
   localparam int          MAX_REPORTS     = 10;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   // one stream byte waiting to be sent
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              is_last;
   } stream_byte_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIXEL_W-1:0]    rsp_pixel_value;
   logic [RUN_W-1:0]      rsp_run_length;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // decode model: configuration copy and stream state
   logic [BPP_W-1:0]      cfg_bpp;
   logic [IMAGE_W-1:0]    cfg_image;
   logic                  want_count;
   int unsigned           byte_index;
   logic [RUN_W-1:0]      run_count;
   logic [PIXEL_W-1:0]    pixel_acc;
   logic [IMAGE_W-1:0]    decoded;
   logic                  img_done;
   logic                  img_error;

   rld_result_type        expected_runs[$];
   stream_byte_t          stream_q[$];

   int unsigned           mismatches   = 0;
   int unsigned           active_items = 0;
   int unsigned           cycle_count  = 0;
   bit                    send_idle    = 1'b1;
   bit                    recv_idle    = 1'b1;

   pixel_run_length_decoder #(
      .MAX_PIXEL_BYTES(PIXEL_BYTES_MAX)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_run_length  (rsp_run_length),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // hard stop if the run hangs
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("pixel_run_length_decoder test failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Decode model
   // --------------------------------------------------------------------------

   // register value 0 acts as 1, anything above the maximum as the maximum
   function automatic int unsigned pixel_size(input logic [BPP_W-1:0] bpp);
      if (bpp == '0)
         return 1;
      if (int'(bpp) > PIXEL_BYTES_MAX)
         return PIXEL_BYTES_MAX;
      return int'(bpp);
   endfunction

   function automatic void clear_stream();
      want_count = 1'b1;
      byte_index = 0;
      run_count  = '0;
      pixel_acc  = '0;
      decoded    = '0;
      img_done   = 1'b0;
      img_error  = 1'b0;
   endfunction

   function automatic void queue_result(input logic [PIXEL_W-1:0] pix,
                                        input logic [RUN_W-1:0] len,
                                        input rld_status_type st);
      rld_result_type r;
      r.pixel_value = pix;
      r.run_length  = len;
      r.status      = st;
      expected_runs.push_back(r);
   endfunction

   // steps the model by one stream byte; returns 0 when the byte is ignored
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      int unsigned     size;
      longint unsigned need;
      longint unsigned room;
      bit              active;
      active = !(img_done || img_error);
      if (active) begin
         if (want_count) begin
            if (b == '0) begin
               queue_result('0, '0, STATUS_ZERO);
               img_error = 1'b1;
            end else if (is_last) begin
               // a count with nothing after it
               queue_result('0, '0, STATUS_TRUNC);
               img_error = 1'b1;
            end else begin
               run_count  = b;
               byte_index = 0;
               pixel_acc  = '0;
               want_count = 1'b0;
            end
         end else begin
            size = pixel_size(cfg_bpp);
            if (byte_index < PACK_LANES)
               pixel_acc = pixel_acc | (32'(b) << (8 * byte_index));
            byte_index++;
            if (byte_index >= size) begin
               need = longint'(run_count) * size;
               room = (decoded >= cfg_image) ? 0 : longint'(cfg_image - decoded);
               want_count = 1'b1;
               byte_index = 0;
               if (need > room) begin
                  // overrun wins over a short stream; decoded is kept
                  queue_result('0, '0, STATUS_OVER);
                  img_error = 1'b1;
               end else begin
                  decoded = decoded + IMAGE_W'(need);
                  if (decoded == cfg_image) begin
                     queue_result(pixel_acc, run_count, STATUS_DONE);
                     img_done = 1'b1;
                  end else if (is_last) begin
                     queue_result('0, '0, STATUS_TRUNC);
                     img_error = 1'b1;
                  end else begin
                     queue_result(pixel_acc, run_count, STATUS_RUN);
                  end
               end
            end else if (is_last) begin
               // stream ends inside a pixel
               queue_result('0, '0, STATUS_TRUNC);
               img_error = 1'b1;
            end
         end
      end
      if (is_last)
         clear_stream();
      return active;
   endfunction

   // --------------------------------------------------------------------------
   // Drivers and checker
   // --------------------------------------------------------------------------

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_result();
      rld_result_type want;
      if (expected_runs.size() == 0) begin
         note_mismatch($sformatf("unexpected item pixel=%h run=%0d status=%0d",
                                 rsp_pixel_value, rsp_run_length, rsp_status));
      end else begin
         want = expected_runs.pop_front();
         if (rsp_pixel_value !== want.pixel_value || rsp_run_length !== want.run_length ||
             rsp_status !== want.status)
            note_mismatch($sformatf("exp pixel=%h run=%0d status=%0d, got pixel=%h run=%0d status=%0d",
                                    want.pixel_value, want.run_length, want.status,
                                    rsp_pixel_value, rsp_run_length, rsp_status));
      end
   endtask

   // result side: take each item, then hold stall for a random number of cycles
   initial begin : result_monitor
      int unsigned hold;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_result();
            hold = recv_idle ? $urandom_range(0, 8) : 0;
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // sends one stream byte after a random gap and steps the model on accept
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (decode_byte(b, is_last))
         active_items++;
   endtask

   // sends stream_q entries [from, upto)
   task automatic send_stream(input int from, input int upto);
      for (int i = from; i < upto; i++)
         send_byte(stream_q[i].data, stream_q[i].is_last);
   endtask

   function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      stream_byte_t s;
      s.data    = b;
      s.is_last = is_last;
      stream_q.push_back(s);
   endfunction

   // input idle, every expected item back, then the block's latency again
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_runs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle, then access cycle until pready
   task automatic csr_write(input rld_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BYTES_PER_PIXEL: cfg_bpp   = value[BPP_W-1:0];
         REG_IMAGE_BYTES:     cfg_image = value[IMAGE_W-1:0];
         default: ;
      endcase
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // reset settings (3 byte pixels, 1 byte image): first run overruns
   task automatic test_reset_config();
      send_byte(8'h01, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h30, 1'b1);
      drain_results();
   endtask

   // four byte pixels, 2^30 byte image: full run, then a stream cut mid pixel
   task automatic test_wide_pixels();
      csr_write(REG_BYTES_PER_PIXEL, 32'd4);
      csr_write(REG_IMAGE_BYTES, 32'h4000_0000);
      send_byte(8'hFF, 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b1);
      drain_results();
   endtask

   // one byte pixels: short image, completion, ignored tail, zero count,
   // last on a count
   task automatic test_single_byte_pixels();
      csr_write(REG_BYTES_PER_PIXEL, 32'd1);
      csr_write(REG_IMAGE_BYTES, 32'd2);
      send_byte(8'h01, 1'b0);
      send_byte(8'h33, 1'b1);
      send_byte(8'h02, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'h07, 1'b1);
      drain_results();
   endtask

   // pixel size 7 acts as 4 against an empty image
   task automatic test_size_clamp();
      csr_write(REG_BYTES_PER_PIXEL, 32'd7);
      csr_write(REG_IMAGE_BYTES, 32'd0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);
      drain_results();
   endtask

   // pixel size 0 acts as 1; image shrunk below what is already decoded
   task automatic test_shrunk_image();
      csr_write(REG_BYTES_PER_PIXEL, 32'd0);
      csr_write(REG_IMAGE_BYTES, 32'd10);
      send_byte(8'h02, 1'b0);
      send_byte(8'h12, 1'b0);
      drain_results();
      csr_write(REG_IMAGE_BYTES, 32'd1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h56, 1'b1);
      drain_results();
   endtask

   task automatic test_random_streams();
      int unsigned      kind;
      int unsigned      size;
      int unsigned      count;
      int unsigned      total;
      int unsigned      cut;
      logic [BPP_W-1:0] bpp;
      logic [IMAGE_W-1:0] image;
      int               count_pos[$];
      active_items = 0;
      while (active_items < RANDOM_ITEMS) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 19);
         bpp  = ($urandom_range(0, 7) == 0) ? BPP_W'($urandom_range(0, 7))
                                            : BPP_W'($urandom_range(1, 4));
         size = pixel_size(bpp);
         stream_q.delete();
         count_pos.delete();
         total = 0;
         // well-formed image: runs whose bytes fill it exactly
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 7))
               0:       count = 255;
               1, 2:    count = $urandom_range(1, 4);
               default: count = $urandom_range(1, 255);
            endcase
            count_pos.push_back(stream_q.size());
            add_byte(BYTE_W'(count), 1'b0);
            repeat (size) add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            total += count * size;
         end
         stream_q[stream_q.size()-1].is_last = 1'b1;
         image = IMAGE_W'(total);
         case (kind)
            10, 11: begin
               // stream cut short
               cut = $urandom_range(1, stream_q.size() - 1);
               while (stream_q.size() > cut) void'(stream_q.pop_back());
               stream_q[stream_q.size()-1].is_last = 1'b1;
            end
            12: stream_q[count_pos[$urandom_range(0, count_pos.size() - 1)]].data = '0;
            13: image = IMAGE_W'($urandom_range(0, total - 1));
            14, 15: begin
               // bytes after completion, last on the final one
               stream_q[stream_q.size()-1].is_last = 1'b0;
               repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
               stream_q[stream_q.size()-1].is_last = 1'b1;
            end
            16: begin
               stream_q.delete();
               repeat ($urandom_range(1, 12))
                  add_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
               stream_q[stream_q.size()-1].is_last = 1'b1;
               image = $urandom_range(0, 1) ? IMAGE_W'($urandom_range(1, 64))
                                            : IMAGE_W'($urandom());
            end
            default: ;
         endcase
         drain_results();
         csr_write(REG_BYTES_PER_PIXEL, CSR_DATA_W'(bpp));
         csr_write(REG_IMAGE_BYTES, CSR_DATA_W'(image));
         if (kind >= 17) begin
            // pause mid-stream and change one register while idle
            cut = $urandom_range(1, stream_q.size() - 1);
            send_stream(0, cut);
            drain_results();
            if ($urandom_range(0, 1))
               csr_write(REG_BYTES_PER_PIXEL, CSR_DATA_W'($urandom_range(0, 7)));
            else
               csr_write(REG_IMAGE_BYTES, CSR_DATA_W'($urandom_range(0, total + 8)));
            send_stream(cut, stream_q.size());
         end else begin
            send_stream(0, stream_q.size());
         end
      end
      drain_results();
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      cfg_bpp   = BPP_RESET;
      cfg_image = IMAGE_RESET;
      clear_stream();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_wide_pixels();
      test_single_byte_pixels();
      test_size_clamp();
      test_shrunk_image();
      test_random_streams();

      drain_results();
      if (expected_runs.size() != 0)
         note_mismatch($sformatf("%0d expected items never arrived", expected_runs.size()));
      if (mismatches == 0)
         $display("pixel_run_length_decoder test passed");
      else
         $display("pixel_run_length_decoder test failed");
      $finish;
   end

endmodule
